@@ hw/rtl/lbev_pkg.sv @@
// ----------------------------------------------------------------------------
// lbev_pkg
// Types, register map and arithmetic step functions shared by the lidar
// bird's-eye-view projection pipeline.
// ----------------------------------------------------------------------------
package lbev_pkg;

	localparam int GRID_DEFAULT      = 128;
	localparam int CELL_SIZE_DEFAULT = 26;

	localparam int NUM_REGS  = 8;
	localparam int REG_IDX_W = 3;

	localparam logic [REG_IDX_W-1:0] REG_BOX_X_LOW      = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_BOX_X_HIGH     = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_BOX_Y_LOW      = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_BOX_Y_HIGH     = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_BOX_Z_LOW      = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_BOX_Z_HIGH     = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_HEIGHT_FLOOR   = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_HEIGHT_CEILING = 3'd7;

	localparam logic signed [15:0] REG_RESET [NUM_REGS] = '{
		-16'sd1280, 16'sd1280, -16'sd1280, 16'sd1280,
		-16'sd1280, 16'sd1280, -16'sd128, 16'sd512
	};

	// Iterations of the divider and of the square root done in one stage.
	localparam int STEPS = 4;

	localparam logic signed [15:0] W_LIMIT  = 16'sd512;
	localparam logic signed [40:0] RW_LIMIT = 41'sd33554432;

	typedef struct packed {
		logic              ok;
		logic              done;
		logic [16:0]       dx;
		logic [16:0]       dy;
		logic [13:0]       cell_idx;
		logic              hok;
		logic [15:0]       span;
		logic [16:0]       hrem;
		logic [15:0]       hq;
		logic [15:0]       inorm;
		logic signed [15:0] w;
		logic [31:0]       x2;
		logic [31:0]       y2;
		logic [31:0]       z2;
		logic [47:0]       rad;
		logic [26:0]       srem;
		logic [23:0]       sroot;
		logic signed [40:0] rw;
	} pipe_t;

	typedef struct packed {
		logic [16:0] rem;
		logic [15:0] q;
	} div_t;

	typedef struct packed {
		logic [47:0] rad;
		logic [26:0] rem;
		logic [23:0] root;
	} sqrt_t;

	typedef struct packed {
		logic        in_box;
		logic [13:0] cell_index;
		logic [15:0] height_norm;
		logic [15:0] intensity_norm;
		logic [15:0] range_norm;
		logic        cloud_done;
	} result_t;

	// Restoring division, one quotient bit per iteration, MSB first.
	function automatic div_t div_steps(input div_t cur, input logic [15:0] den);
		div_t r;
		r = cur;
		for (int i = 0; i < STEPS; i++) begin
			if (r.rem >= {1'b0, den}) begin
				r.rem = r.rem - {1'b0, den};
				r.q   = {r.q[14:0], 1'b1};
			end else begin
				r.q   = {r.q[14:0], 1'b0};
			end
			r.rem = {r.rem[15:0], 1'b0};
		end
		return r;
	endfunction

	// Digit-by-digit floor square root, two radicand bits per iteration.
	function automatic sqrt_t sqrt_steps(input sqrt_t cur);
		sqrt_t       r;
		logic [26:0] trial;
		r = cur;
		for (int i = 0; i < STEPS; i++) begin
			r.rem = {r.rem[24:0], r.rad[47:46]};
			r.rad = {r.rad[45:0], 2'b00};
			trial = {1'b0, r.root, 2'b01};
			if (r.rem >= trial) begin
				r.rem  = r.rem - trial;
				r.root = {r.root[22:0], 1'b1};
			end else begin
				r.root = {r.root[22:0], 1'b0};
			end
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/lbev_if.sv @@
// ----------------------------------------------------------------------------
// lbev_if
// Valid/ready channels for lidar points and for projected cell results.
// ----------------------------------------------------------------------------
interface lbev_point_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] x_coord;
	logic signed [15:0] y_coord;
	logic signed [15:0] z_coord;
	logic signed [15:0] reflectance;
	logic               end_of_cloud;

	modport source (output valid, x_coord, y_coord, z_coord, reflectance, end_of_cloud,
		input ready);
	modport sink (input valid, x_coord, y_coord, z_coord, reflectance, end_of_cloud,
		output ready);
endinterface

interface lbev_cell_if;
	logic        valid;
	logic        ready;
	logic        in_box;
	logic [13:0] cell_index;
	logic [15:0] height_norm;
	logic [15:0] intensity_norm;
	logic [15:0] range_norm;
	logic        cloud_done;

	modport source (output valid, in_box, cell_index, height_norm, intensity_norm,
		range_norm, cloud_done, input ready);
	modport sink (input valid, in_box, cell_index, height_norm, intensity_norm,
		range_norm, cloud_done, output ready);
endinterface

@@ hw/rtl/lidar_bev_point_projection.sv @@
// ----------------------------------------------------------------------------
// lidar_bev_point_projection
// Box test, grid cell index and normalized height, intensity and range
// features for one lidar point per request.
// ----------------------------------------------------------------------------
// Usage:
// Points enter on the points channel and one result leaves on the cells
// channel for every point, in order. A point outside the box or the grid
// gives in_box low and zero features; cloud_done always copies end_of_cloud.
// The pipeline has ten register stages. One point is taken in every cycle
// while the receiver does not stall; the depth is set by the square root,
// which spends six stages at four root bits each, and by the height
// divider, which spends four stages at four quotient bits.
// When the receiver stalls, the whole pipeline holds its contents and
// points.ready falls; nothing is dropped or repeated, and the output register
// keeps the pending result. Reset clears all valid bits and loads the box and
// height band registers with their defaults. Registers are written through
// wr_en, wr_index and wr_data, and take effect on the next request; write them
// only while the pipeline is empty.
// ----------------------------------------------------------------------------
module lidar_bev_point_projection #(
	parameter int GRID      = lbev_pkg::GRID_DEFAULT,
	parameter int CELL_SIZE = lbev_pkg::CELL_SIZE_DEFAULT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [lbev_pkg::REG_IDX_W-1:0]   wr_index,
	input  logic [15:0]                      wr_data,
	lbev_point_if.sink                       points,
	lbev_cell_if.source                      cells
);
	import lbev_pkg::*;

	// Division by the cell size as a multiply by a rounded-up reciprocal;
	// exact for all 17-bit offsets.
	localparam int          CL    = $clog2(CELL_SIZE);
	localparam int          SH    = 17 + CL;
	localparam logic [18:0] RECIP = 19'((64'd1 << SH) / CELL_SIZE + 1);

	logic signed [15:0] cfg_q [NUM_REGS];

	logic    en;
	logic    v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	pipe_t   p_s1, p_s2, p_s3, p_s4, p_s5, p_s6, p_s7, p_s8, p_s9;
	pipe_t   n1, n2, n3, n4, n5, n6, n7, n8, n9;
	result_t r_s10, n10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) cfg_q[i] <= REG_RESET[i];
		end else if (wr_en) begin
			cfg_q[wr_index] <= wr_data;
		end
	end

	assign en           = !v_s10 || cells.ready;
	assign points.ready = en;

	// Stage 1: box test, offsets, height band, intensity and squares.
	always_comb begin
		logic signed [15:0] zc, wc;
		logic signed [16:0] dxs, dys, num, spn, wt;
		logic signed [15:0] fl, ce;
		n1      = '0;
		fl      = cfg_q[REG_HEIGHT_FLOOR];
		ce      = cfg_q[REG_HEIGHT_CEILING];
		n1.ok   = (points.x_coord > cfg_q[REG_BOX_X_LOW]) &&
		          (points.x_coord < cfg_q[REG_BOX_X_HIGH]) &&
		          (points.y_coord > cfg_q[REG_BOX_Y_LOW]) &&
		          (points.y_coord < cfg_q[REG_BOX_Y_HIGH]) &&
		          (points.z_coord > cfg_q[REG_BOX_Z_LOW]) &&
		          (points.z_coord < cfg_q[REG_BOX_Z_HIGH]);
		n1.done = points.end_of_cloud;
		dxs     = {points.x_coord[15], points.x_coord} -
		          {cfg_q[REG_BOX_X_LOW][15], cfg_q[REG_BOX_X_LOW]};
		dys     = {points.y_coord[15], points.y_coord} -
		          {cfg_q[REG_BOX_Y_LOW][15], cfg_q[REG_BOX_Y_LOW]};
		n1.dx   = dxs;
		n1.dy   = dys;
		zc = points.z_coord;
		if (zc < fl) zc = fl;
		if (zc > ce) zc = ce;
		num     = {zc[15], zc} - {fl[15], fl};
		spn     = {ce[15], ce} - {fl[15], fl};
		n1.hok  = ce > fl;
		n1.span = spn[15:0];
		n1.hrem = num;
		wc = points.reflectance;
		if (wc < -W_LIMIT) wc = -W_LIMIT;
		if (wc > W_LIMIT) wc = W_LIMIT;
		wt       = {wc[15], wc} + 17'sd512;
		n1.inorm = {wt[10:0], 5'b00000};
		n1.w     = points.reflectance;
		n1.x2    = 32'(points.x_coord * points.x_coord);
		n1.y2    = 32'(points.y_coord * points.y_coord);
		n1.z2    = 32'(points.z_coord * points.z_coord);
	end

	// Stage 2: cell coordinates, grid test, squared range, first divider bits.
	always_comb begin
		logic [35:0] px, py;
		logic [31:0] sq;
		div_t        d;
		n2     = p_s1;
		px     = p_s1.dx * RECIP;
		py     = p_s1.dy * RECIP;
		n2.dx  = 17'(px >> SH);
		n2.dy  = 17'(py >> SH);
		n2.ok  = p_s1.ok && (32'(n2.dx) < 32'(GRID)) && (32'(n2.dy) < 32'(GRID));
		sq     = p_s1.x2 + p_s1.y2 + p_s1.z2;
		n2.rad = {sq, 16'h0000};
		n2.srem  = '0;
		n2.sroot = '0;
		d       = div_steps('{rem: p_s1.hrem, q: p_s1.hq}, p_s1.span);
		n2.hrem = d.rem;
		n2.hq   = d.q;
	end

	// Stage 3: cell index; divider continues and square root starts.
	always_comb begin
		div_t  d;
		sqrt_t s;
		logic [31:0] ci;
		n3          = p_s2;
		ci          = 32'(p_s2.dx) * 32'(GRID) + 32'(p_s2.dy);
		n3.cell_idx = ci[13:0];
		d           = div_steps('{rem: p_s2.hrem, q: p_s2.hq}, p_s2.span);
		n3.hrem     = d.rem;
		n3.hq       = d.q;
		s           = sqrt_steps('{rad: p_s2.rad, rem: p_s2.srem, root: p_s2.sroot});
		n3.rad      = s.rad;
		n3.srem     = s.rem;
		n3.sroot    = s.root;
	end

	always_comb begin
		div_t  d;
		sqrt_t s;
		n4       = p_s3;
		d        = div_steps('{rem: p_s3.hrem, q: p_s3.hq}, p_s3.span);
		n4.hrem  = d.rem;
		n4.hq    = d.q;
		s        = sqrt_steps('{rad: p_s3.rad, rem: p_s3.srem, root: p_s3.sroot});
		n4.rad   = s.rad;
		n4.srem  = s.rem;
		n4.sroot = s.root;
	end

	always_comb begin
		div_t  d;
		sqrt_t s;
		n5       = p_s4;
		d        = div_steps('{rem: p_s4.hrem, q: p_s4.hq}, p_s4.span);
		n5.hrem  = d.rem;
		n5.hq    = d.q;
		s        = sqrt_steps('{rad: p_s4.rad, rem: p_s4.srem, root: p_s4.sroot});
		n5.rad   = s.rad;
		n5.srem  = s.rem;
		n5.sroot = s.root;
	end

	always_comb begin
		sqrt_t s;
		n6       = p_s5;
		s        = sqrt_steps('{rad: p_s5.rad, rem: p_s5.srem, root: p_s5.sroot});
		n6.rad   = s.rad;
		n6.srem  = s.rem;
		n6.sroot = s.root;
	end

	always_comb begin
		sqrt_t s;
		n7       = p_s6;
		s        = sqrt_steps('{rad: p_s6.rad, rem: p_s6.srem, root: p_s6.sroot});
		n7.rad   = s.rad;
		n7.srem  = s.rem;
		n7.sroot = s.root;
	end

	always_comb begin
		sqrt_t s;
		n8       = p_s7;
		s        = sqrt_steps('{rad: p_s7.rad, rem: p_s7.srem, root: p_s7.sroot});
		n8.rad   = s.rad;
		n8.srem  = s.rem;
		n8.sroot = s.root;
	end

	// Stage 9: range times intensity.
	always_comb begin
		n9    = p_s8;
		n9.rw = $signed({1'b0, p_s8.sroot}) * p_s8.w;
	end

	// Stage 10: clamp, scale and zero rejected points.
	always_comb begin
		logic signed [40:0] rc, rs;
		rc = p_s9.rw;
		if (rc < -RW_LIMIT) rc = -RW_LIMIT;
		if (rc > RW_LIMIT) rc = RW_LIMIT;
		rs  = rc + RW_LIMIT;
		n10 = '0;
		n10.cloud_done = p_s9.done;
		if (p_s9.ok) begin
			n10.in_box         = 1'b1;
			n10.cell_index     = p_s9.cell_idx;
			n10.height_norm    = p_s9.hok ? p_s9.hq : 16'h0000;
			n10.intensity_norm = p_s9.inorm;
			n10.range_norm     = rs[26:11];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; v_s5 <= 1'b0;
			v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0; v_s9 <= 1'b0; v_s10 <= 1'b0;
		end else if (en) begin
			v_s1 <= points.valid;
			v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3; v_s5 <= v_s4;
			v_s6 <= v_s5; v_s7 <= v_s6; v_s8 <= v_s7; v_s9 <= v_s8; v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1 <= n1; p_s2 <= n2; p_s3 <= n3; p_s4 <= n4; p_s5 <= n5;
			p_s6 <= n6; p_s7 <= n7; p_s8 <= n8; p_s9 <= n9; r_s10 <= n10;
		end
	end

	assign cells.valid          = v_s10;
	assign cells.in_box         = r_s10.in_box;
	assign cells.cell_index     = r_s10.cell_index;
	assign cells.height_norm    = r_s10.height_norm;
	assign cells.intensity_norm = r_s10.intensity_norm;
	assign cells.range_norm     = r_s10.range_norm;
	assign cells.cloud_done     = r_s10.cloud_done;

	// A stalled output freezes the front of the pipeline as well.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(cells.valid && !cells.ready) |=> ($stable(v_s1) && $stable(v_s5)))
		else $error("pipeline advanced during an output stall");

	// All features are fractions no larger than one.
	a_feat_range: assert property (@(posedge clk) disable iff (!arst_n)
		cells.valid |-> (cells.height_norm <= 16'd32768 &&
		cells.intensity_norm <= 16'd32768 && cells.range_norm <= 16'd32768))
		else $error("normalized feature above one");

	// A rejected point leaves with in_box low, a zero cell index and zero range.
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s9 && !p_s9.ok && en) |=> (cells.valid && !cells.in_box &&
		cells.cell_index == 14'd0 && cells.range_norm == 16'd0))
		else $error("rejected point produced nonzero fields");

endmodule
